@@ design/prq_pkg.sv @@
`default_nettype none

package prq_pkg;

  localparam int unsigned DEPTH   = 128;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned OCC_W   = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W = ID_W + PRIO_W;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // entry layout: priority in the low bits, id above
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occ;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    entry_t            wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = p - 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/priority_ring_queue.sv @@
// channel   dir  tdata                                          tuser
// s_axis    in   [15:0] entry_id, [23:16] priority_req           [0] op
// m_axis    out  [15:0] out_entry_id, [23:16] out_priority,      [1:0] status
//                [31:24] occupancy
//
// enqueue walks back past each held entry of larger priority (up to 127), then writes;
// the walk moves one entry per cycle, with one ram read and one ram write per move
// dequeue passes IDLE, DEQ and DONE, a refused op only IDLE and DONE; then the output register
// reset clears head, tail, count and the output valid; the ram is not cleared
// a stalled m_axis holds the finished word and the next op waits in the sequencer
`default_nettype none

module priority_ring_queue
  import prq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // entry_id, priority_req
  input  wire logic [0:0]  s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // out_entry_id, out_priority, occupancy
  output logic [1:0]       m_axis_tuser   // status
);

  res_t     res;
  mem_req_t mem_req;
  entry_t   rdata;
  logic     res_ready;

  logic              m_valid_q, m_valid_d;
  logic [31:0]       m_data_q, m_data_d;
  logic [STAT_W-1:0] m_user_q, m_user_d;

  prq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser[0]),
    .in_id_i     (s_axis_tdata[ID_W-1:0]),
    .in_prio_i   (s_axis_tdata[ID_W+PRIO_W-1:ID_W]),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_o       (mem_req),
    .rdata_i     (rdata)
  );

  prq_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // output register frees the sequencer once the word is parked
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (res.valid && res_ready) begin
      m_valid_d = 1'b1;
      m_data_d  = {res.occ, res.prio, res.id};
      m_user_d  = res.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

@@ design/prq_store.sv @@
`default_nettype none

module prq_store
  import prq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/prq_ctrl.sv @@
`default_nettype none

module prq_ctrl
  import prq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              in_op_i,
  input  wire logic [ID_W-1:0]   in_id_i,
  input  wire logic [PRIO_W-1:0] in_prio_i,
  output res_t                   res_o,
  input  wire logic              res_ready_i,
  output mem_req_t               mem_o,
  input  wire entry_t            rdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DEQ  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  off_q, off_d;
  logic [IDX_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IDX_W-1:0]  rd_ptr_q, rd_ptr_d;
  entry_t            new_q, new_d;
  res_t              res_q, res_d;
  logic              stop_walk;

  // shared compare: stop when at the head or the earlier entry is not larger
  assign stop_walk = (off_q == '0) || (rdata_i.prio <= new_q.prio);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    off_d    = off_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    new_d    = new_q;
    res_d    = res_q;
    mem_o    = '0;
    res_d.valid = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d.id   = '0;
          res_d.prio = '0;
          if (in_op_i == OP_ENQ) begin
            if (count_q == CNT_W'(DEPTH)) begin
              res_d.status = STAT_FULL;
              res_d.occ    = OCC_W'(count_q);
              state_d      = ST_DONE;
            end else begin
              new_d.id     = in_id_i;
              new_d.prio   = in_prio_i;
              wr_ptr_d     = tail_q;
              rd_ptr_d     = ring_dec(tail_q);
              mem_o.re     = 1'b1;
              mem_o.raddr  = ring_dec(tail_q);
              off_d        = count_q;
              count_d      = count_q + 1'b1;
              tail_d       = ring_inc(tail_q);
              res_d.status = STAT_OK;
              res_d.occ    = OCC_W'(count_q + 1'b1);
              state_d      = ST_WALK;
            end
          end else begin
            if (count_q == '0) begin
              res_d.status = STAT_EMPTY;
              res_d.occ    = '0;
              state_d      = ST_DONE;
            end else begin
              mem_o.re     = 1'b1;
              mem_o.raddr  = head_q;
              count_d      = count_q - 1'b1;
              if (count_q == CNT_W'(1)) begin
                head_d = '0;
                tail_d = '0;
              end else begin
                head_d = ring_inc(head_q);
              end
              res_d.status = STAT_OK;
              res_d.occ    = OCC_W'(count_q - 1'b1);
              state_d      = ST_DEQ;
            end
          end
        end
      end
      ST_WALK: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = wr_ptr_q;
        if (stop_walk) begin
          mem_o.wdata = new_q;
          state_d     = ST_DONE;
        end else begin
          // move the larger entry one slot toward the tail
          mem_o.wdata = rdata_i;
          mem_o.re    = 1'b1;
          mem_o.raddr = ring_dec(rd_ptr_q);
          wr_ptr_d    = rd_ptr_q;
          rd_ptr_d    = ring_dec(rd_ptr_q);
          off_d       = off_q - 1'b1;
        end
      end
      ST_DEQ: begin
        res_d.id   = rdata_i.id;
        res_d.prio = rdata_i.prio;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        res_d.valid = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q    <= off_d;
    wr_ptr_q <= wr_ptr_d;
    rd_ptr_q <= rd_ptr_d;
    new_q    <= new_d;
    res_q    <= res_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_o.valid = (state_q == ST_DONE);
  assign res_o.status = res_q.status;
  assign res_o.id     = res_q.id;
  assign res_o.prio   = res_q.prio;
  assign res_o.occ    = res_q.occ;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> off_q < count_q)
    else $error("walk offset outside occupied region");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> (head_q == '0 && tail_q == '0))
    else $error("empty queue with moved pointers");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && stop_walk) |=> state_q == ST_DONE)
    else $error("walk did not finish after stop");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == STAT_FULL) |-> res_o.occ == OCC_W'(DEPTH))
    else $error("full refusal with wrong occupancy");
`endif

endmodule

`default_nettype wire
